[hdl/packet_filter_checksum_router_assert.svh]
// Assertion macros shared by the packet filter RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef PACKET_FILTER_CHECKSUM_ROUTER_ASSERT_SVH
`define PACKET_FILTER_CHECKSUM_ROUTER_ASSERT_SVH

// Same-cycle implication, off while in reset
`define PFCR_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pfcr assertion failed");

// Next-cycle implication, off while in reset
`define PFCR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pfcr assertion failed");

`endif

[hdl/pfcr_pkg.sv]
// Package for the packet filter / checksum router: sizes, codes and helpers.
// No dependencies; used by packet_filter_checksum_router.
package pfcr_pkg;

    localparam int NUM_PORTS   = 3;
    localparam int NUM_CLASSES = 3;

    localparam logic [15:0] ALL_ONES = 16'hffff;

    // stream widths (fields packed from bit 0 up, padded to whole bytes)
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 168;

    // mask for a broadcast copy: every existing port bit
    localparam logic [2:0] BCAST_MASK = 3'(((1 << NUM_PORTS) - 1) & 7);

    // configuration register indexes
    localparam logic [2:0] CFG_SRC_REJ_A = 3'd0;
    localparam logic [2:0] CFG_SRC_REJ_B = 3'd1;
    localparam logic [2:0] CFG_SRC_REJ_C = 3'd2;
    localparam logic [2:0] CFG_PORT0_DST = 3'd3;
    localparam logic [2:0] CFG_PORT1_DST = 3'd4;
    localparam logic [2:0] CFG_PORT2_DST = 3'd5;
    localparam logic [2:0] CFG_BCAST_DST = 3'd6;

    typedef enum logic [2:0] {
        VERDICT_FORWARD   = 3'd0,
        VERDICT_SRC_REJ   = 3'd1,
        VERDICT_CSUM_BAD  = 3'd2,
        VERDICT_BAD_CLASS = 3'd3,
        VERDICT_NO_ROUTE  = 3'd4
    } verdict_t;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // low < v < high, bounds packed high word = low bound
    function automatic logic in_open(input logic [63:0] rng, input logic [31:0] v);
        return (v > rng[63:32]) && (v < rng[31:0]);
    endfunction

    // low <= v <= high
    function automatic logic in_closed(input logic [63:0] rng, input logic [31:0] v);
        return (v >= rng[63:32]) && (v <= rng[31:0]);
    endfunction

endpackage

[hdl/packet_filter_checksum_router.sv]
// Packet filter with ones'-complement checksum, source filter and port router.
// Depends on pfcr_pkg and packet_filter_checksum_router_assert.svh.
//
// Packet words stream in on the s_ side at one word per clock, back to back.
// Each word is registered, then folded into a 16-bit ones'-complement sum. The
// word flagged by s_tlast carries the side-band fields; its verdict word is
// loaded into the result register for the m_ side. Verdict priority: source in
// an open reject range, checksum not all ones, class not below NUM_CLASSES,
// else routed (port 0, 1, 2, then broadcast, or no route). The result register
// is the only back-pressure point: while it holds an untaken verdict, a further
// last word waits in the input register and s_tready drops; non-last words keep
// flowing. Sustained rate is one word per cycle while verdicts are taken. The
// user must write configuration through cfg_we/cfg_addr/cfg_data only while the
// block is idle; the block does not enforce this. Index 7 is ignored.
`include "packet_filter_checksum_router_assert.svh"

module packet_filter_checksum_router
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_addr,
    input  logic [63:0]                      cfg_data,
    // packet word stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // word[15:0], source_addr[47:16], dest_addr[79:48], age[143:80]
    input  logic [pfcr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,   // last_word
    input  logic [1:0]                       s_tuser,   // traffic_class[1:0]
    // verdict stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // port_mask[2:0], queue_class[4:3], worst_age[68:5],
    // forwarded_count[100:69], source_reject_count[132:101],
    // checksum_reject_count[164:133], zero pad[167:165]
    output logic [pfcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]                       m_tuser    // verdict[2:0]
);

    // configuration
    logic [63:0] src_rej_reg [3];
    logic [63:0] dst_rng_reg [4];   // ports 0..2, then broadcast

    // input register
    logic        in_valid_reg;
    logic [15:0] in_word_reg;
    logic        in_last_reg;
    logic [31:0] in_src_reg;
    logic [31:0] in_dst_reg;
    logic [1:0]  in_cls_reg;
    logic [63:0] in_age_reg;

    // state
    logic [15:0] sum_reg;
    logic [63:0] worst_reg [pfcr_pkg::NUM_CLASSES];
    logic [31:0] fwd_total_reg;
    logic [31:0] src_total_reg;
    logic [31:0] csum_total_reg;

    // result register
    logic                 out_valid_reg;
    pfcr_pkg::verdict_t   out_verdict_reg;
    logic [2:0]           out_mask_reg;
    logic [1:0]           out_qcls_reg;
    logic [63:0]          out_worst_reg;
    logic [31:0]          out_fwd_reg;
    logic [31:0]          out_src_reg;
    logic [31:0]          out_csum_reg;

    // datapath
    logic               out_free;
    logic               fire;
    logic               take_in;
    logic               result_load;
    logic [15:0]        sum_next;
    logic               src_hit;
    logic               class_ok;
    logic [63:0]        cur_worst;
    logic [63:0]        worst_next;
    logic [2:0]         mask_next;
    pfcr_pkg::verdict_t verdict_next;
    logic [31:0]        fwd_total_next;
    logic [31:0]        src_total_next;
    logic [31:0]        csum_total_next;

    assign out_free    = !out_valid_reg || m_tready;
    assign fire        = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready    = !in_valid_reg || fire;
    assign take_in     = s_tvalid && s_tready;
    assign result_load = fire && in_last_reg;

    assign sum_next = pfcr_pkg::oc_add(sum_reg, in_word_reg);

    // classification of the word in the input register
    always_comb
    begin
        src_hit   = pfcr_pkg::in_open(src_rej_reg[0], in_src_reg) ||
                    pfcr_pkg::in_open(src_rej_reg[1], in_src_reg) ||
                    pfcr_pkg::in_open(src_rej_reg[2], in_src_reg);
        class_ok  = int'(in_cls_reg) < pfcr_pkg::NUM_CLASSES;

        cur_worst = '0;
        for (int i = 0; i < pfcr_pkg::NUM_CLASSES; i++)
        begin
            if (int'(in_cls_reg) == i)
                cur_worst = worst_reg[i];
        end
        worst_next = (cur_worst < in_age_reg) ? in_age_reg : cur_worst;

        // lowest matching port wins
        mask_next = '0;
        for (int k = 2; k >= 0; k--)
        begin
            if (k < pfcr_pkg::NUM_PORTS && pfcr_pkg::in_closed(dst_rng_reg[k], in_dst_reg))
                mask_next = 3'b001 << k;
        end
        if (mask_next == 3'b000 && pfcr_pkg::in_closed(dst_rng_reg[3], in_dst_reg))
            mask_next = pfcr_pkg::BCAST_MASK;

        fwd_total_next  = fwd_total_reg;
        src_total_next  = src_total_reg;
        csum_total_next = csum_total_reg;
        if (src_hit)
        begin
            verdict_next   = pfcr_pkg::VERDICT_SRC_REJ;
            src_total_next = src_total_reg + 32'd1;
        end
        else if (sum_next != pfcr_pkg::ALL_ONES)
        begin
            verdict_next    = pfcr_pkg::VERDICT_CSUM_BAD;
            csum_total_next = csum_total_reg + 32'd1;
        end
        else if (!class_ok)
            verdict_next = pfcr_pkg::VERDICT_BAD_CLASS;
        else if (mask_next != 3'b000)
        begin
            verdict_next   = pfcr_pkg::VERDICT_FORWARD;
            fwd_total_next = fwd_total_reg + 32'd1;
        end
        else
            verdict_next = pfcr_pkg::VERDICT_NO_ROUTE;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                src_rej_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                dst_rng_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pfcr_pkg::CFG_SRC_REJ_A: src_rej_reg[0] <= cfg_data;
                pfcr_pkg::CFG_SRC_REJ_B: src_rej_reg[1] <= cfg_data;
                pfcr_pkg::CFG_SRC_REJ_C: src_rej_reg[2] <= cfg_data;
                pfcr_pkg::CFG_PORT0_DST: dst_rng_reg[0] <= cfg_data;
                pfcr_pkg::CFG_PORT1_DST: dst_rng_reg[1] <= cfg_data;
                pfcr_pkg::CFG_PORT2_DST: dst_rng_reg[2] <= cfg_data;
                pfcr_pkg::CFG_BCAST_DST: dst_rng_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_word_reg <= s_tdata[15:0];
            in_src_reg  <= s_tdata[47:16];
            in_dst_reg  <= s_tdata[79:48];
            in_age_reg  <= s_tdata[143:80];
            in_last_reg <= s_tlast;
            in_cls_reg  <= s_tuser;
        end
    end

    // running sum, worst ages and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            fwd_total_reg  <= '0;
            src_total_reg  <= '0;
            csum_total_reg <= '0;
            for (int i = 0; i < pfcr_pkg::NUM_CLASSES; i++)
                worst_reg[i] <= '0;
        end
        else if (fire)
        begin
            sum_reg <= in_last_reg ? 16'd0 : sum_next;
            if (in_last_reg)
            begin
                fwd_total_reg  <= fwd_total_next;
                src_total_reg  <= src_total_next;
                csum_total_reg <= csum_total_next;
                if (verdict_next == pfcr_pkg::VERDICT_FORWARD ||
                    verdict_next == pfcr_pkg::VERDICT_NO_ROUTE)
                begin
                    for (int i = 0; i < pfcr_pkg::NUM_CLASSES; i++)
                    begin
                        if (int'(in_cls_reg) == i)
                            worst_reg[i] <= worst_next;
                    end
                end
            end
        end
    end

    // result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result register: payload; source, checksum and class rejects report zero mask/class/age
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_verdict_reg <= verdict_next;
            out_fwd_reg     <= fwd_total_next;
            out_src_reg     <= src_total_next;
            out_csum_reg    <= csum_total_next;
            if (verdict_next == pfcr_pkg::VERDICT_FORWARD ||
                verdict_next == pfcr_pkg::VERDICT_NO_ROUTE)
            begin
                out_mask_reg  <= (verdict_next == pfcr_pkg::VERDICT_FORWARD) ? mask_next : 3'b000;
                out_qcls_reg  <= in_cls_reg;
                out_worst_reg <= worst_next;
            end
            else
            begin
                out_mask_reg  <= 3'b000;
                out_qcls_reg  <= 2'b00;
                out_worst_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_verdict_reg;
    assign m_tdata  = {3'b000, out_csum_reg, out_src_reg, out_fwd_reg,
                       out_worst_reg, out_qcls_reg, out_mask_reg};

    // sum restarts after every last word
    `PFCR_ASSERT_NEXT(a_sum_cleared, fire && in_last_reg, sum_reg == 16'd0)
    // a last word never overwrites a verdict that is still waiting
    `PFCR_ASSERT_NOW(a_no_overwrite, result_load, out_free)
    // forwarded total moves by one exactly with a forward verdict
    `PFCR_ASSERT_NEXT(a_fwd_count, result_load && verdict_next == pfcr_pkg::VERDICT_FORWARD,
        fwd_total_reg == $past(fwd_total_reg) + 32'd1)
    // a port mask is shown only for forwarded packets
    `PFCR_ASSERT_NOW(a_mask_verdict, out_valid_reg,
        (out_verdict_reg == pfcr_pkg::VERDICT_FORWARD) == (out_mask_reg != 3'b000))
    // a held input word stays held
    `PFCR_ASSERT_NEXT(a_in_hold, in_valid_reg && !fire, in_valid_reg)

endmodule
